### rtl/slt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types, character codes and helpers of the shell line tokenizer.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int MAX_LINE_DEF = 4096;
	localparam int POSITION_W   = 12;
	localparam int IN_TDATA_W   = 8;
	localparam int OUT_TDATA_W  = 24;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_LESS  = 8'h3C;
	localparam logic [7:0] CH_GREAT = 8'h3E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_ARG    = 2'd1,
		KIND_INFILE = 2'd2,
		KIND_OUTFILE = 2'd3
	} kind_t;

	typedef struct packed {
		logic after_space;
		logic after_pipe;
		logic amp_pending;
		logic after_less;
		logic after_greater;
		logic in_word;
	} flags_t;

	localparam flags_t FLAGS_RESET = '{
		after_space:   1'b1,
		after_pipe:    1'b1,
		amp_pending:   1'b0,
		after_less:    1'b0,
		after_greater: 1'b0,
		in_word:       1'b0
	};

	typedef struct packed {
		logic                  seq_break;
		logic                  set_append;
		logic                  new_command;
		logic                  new_arg;
		kind_t                 start_kind;
		logic                  end_word;
		logic                  run_list;
		logic [POSITION_W-1:0] position;
	} evt_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

### rtl/slt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_core
// Per-byte event decode and next line state, purely combinational.
// ----------------------------------------------------------------------------
module slt_core
	import slt_pkg::*;
#(
	parameter int MAX_LINE = MAX_LINE_DEF,
	localparam int POS_W = $clog2(MAX_LINE)
) (
	input  flags_t           flags,
	input  logic [POS_W-1:0] pos,
	input  logic [7:0]       ch,
	input  logic             last,
	output evt_t             evt,
	output flags_t           flags_nxt,
	output logic [POS_W-1:0] pos_nxt
);

	logic   sp, amp, bar, lt, gt, word;
	flags_t f;

	always_comb begin
		sp   = is_blank(ch);
		amp  = (ch == CH_AMP);
		bar  = (ch == CH_BAR);
		lt   = (ch == CH_LESS);
		gt   = (ch == CH_GREAT);
		word = !sp && !lt && !gt && !bar && !amp;
		f    = flags;
		evt  = '0;

		if (amp) begin
			if (f.amp_pending) begin
				evt.seq_break = 1'b1;
				f.amp_pending = 1'b0;
				f.after_space = 1'b1;
				f.after_pipe  = 1'b1;
			end else begin
				f.amp_pending = 1'b1;
			end
		end
		if (sp) begin
			f.after_space = 1'b1;
		end
		if (bar) begin
			f.after_space = 1'b1;
			f.after_pipe  = 1'b1;
		end
		if (lt) begin
			f.after_less = 1'b1;
		end
		if (gt) begin
			evt.set_append  = f.after_greater;
			f.after_greater = 1'b1;
		end
		if (f.after_pipe && !sp && !bar && !amp) begin
			evt.new_command = 1'b1;
			f.after_greater = 1'b0;
			f.after_less    = 1'b0;
		end
		evt.new_arg = f.after_space && !sp && !f.after_less && !f.after_greater
			&& !bar && !amp;

		if (word) begin
			f.after_space = 1'b0;
			f.after_pipe  = 1'b0;
			if (!f.in_word) begin
				if (f.after_less) begin
					evt.start_kind = KIND_INFILE;
				end else if (f.after_greater) begin
					evt.start_kind = KIND_OUTFILE;
				end else begin
					evt.start_kind = KIND_ARG;
				end
				f.in_word = 1'b1;
			end
		end else begin
			evt.end_word = 1'b1;
			f.in_word    = 1'b0;
		end

		evt.run_list = last;
		evt.position = POSITION_W'(pos);

		if (last) begin
			flags_nxt = FLAGS_RESET;
			pos_nxt   = '0;
		end else begin
			flags_nxt = f;
			pos_nxt   = (pos < POS_W'(MAX_LINE - 1)) ? pos + POS_W'(1) : pos;
		end
	end

endmodule

### rtl/shell_line_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_line_tokenizer
// Scans a command line byte by byte and emits one token event per byte.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one line byte per request, tlast on the final byte.
//   m_axis returns one event per byte in order; tlast (run_list) marks the
//   event of the final byte, after which the line state returns to reset.
//   Path: an accepted byte passes through the input register, then the result
//   register, where its event becomes valid. Throughput: one byte per cycle
//   while m_axis_tready is high; the flag update between them is combinational.
//   Reset (arst_n low) empties both registers and puts the line state at
//   line start, byte position zero.
//   When m_axis_tready is low, the result register holds; the input
//   register still takes one more byte, then s_axis_tready drops until the
//   result is taken. No request is lost or repeated.
//   Byte position saturates at MAX_LINE - 1; the low 12 bits are reported.
// ----------------------------------------------------------------------------
module shell_line_tokenizer
	import slt_pkg::*;
#(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [7:0] ch
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [0] seq_break, [1] set_append, [2] new_command, [3] new_arg,
	// [5:4] start_kind, [6] end_word, [18:7] position, [23:19] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tlast
);

	localparam int POS_W = $clog2(MAX_LINE);

	logic             valid_s1, last_s1;
	logic [7:0]       ch_s1;
	logic             valid_s2;
	evt_t             evt_s2;
	flags_t           flags_q, flags_nxt;
	logic [POS_W-1:0] pos_q, pos_nxt;
	evt_t             evt;
	logic             out_free, move_s1, take_in;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign move_s1       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	slt_core #(
		.MAX_LINE(MAX_LINE)
	) u_core (
		.flags    (flags_q),
		.pos      (pos_q),
		.ch       (ch_s1),
		.last     (last_s1),
		.evt      (evt),
		.flags_nxt(flags_nxt),
		.pos_nxt  (pos_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= FLAGS_RESET;
			pos_q    <= '0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
			if (move_s1) begin
				flags_q <= flags_nxt;
				pos_q   <= pos_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			ch_s1   <= s_axis_tdata[7:0];
			last_s1 <= s_axis_tlast;
		end
		if (move_s1) begin
			evt_s2 <= evt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tlast  = evt_s2.run_list;
	assign m_axis_tdata  = {5'b0, evt_s2.position, evt_s2.end_word, evt_s2.start_kind,
		evt_s2.new_arg, evt_s2.new_command, evt_s2.set_append, evt_s2.seq_break};

endmodule

### rtl/slt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_checker
// Port-level checks on the tokenizer's event stream.
// ----------------------------------------------------------------------------
module slt_checker
	import slt_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tlast
);

	logic m_req;
	assign m_req = m_axis_tvalid && m_axis_tready;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled event changed");

	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		m_req && m_axis_tlast ##1 m_req |-> m_axis_tdata[18:7] == '0)
		else $error("new line does not start at position zero");

	a_start_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[5:4] != KIND_NONE) |-> !m_axis_tdata[6])
		else $error("word start on a terminator byte");

	a_break_is_sep: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[1]) |-> m_axis_tdata[6])
		else $error("sequence break or append on a word byte");

endmodule

bind shell_line_tokenizer slt_checker u_slt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);
